FILE: hdl/isps_pkg.sv
// ----------------------------------------------------------------------------
// isps_pkg: shared types and constants of the interrupt priority selector
// Field types, item structs, register indexes and the fixed group table.
// ----------------------------------------------------------------------------
package isps_pkg;

    typedef logic [16:0] cause_t;
    typedef logic [15:0] half_t;
    typedef logic [31:0] word_t;
    typedef logic [4:0]  irq_num_t;
    typedef logic [7:0]  cfg_index_t;

    localparam cfg_index_t REG_USER_MASK   = 8'd0;
    localparam cfg_index_t REG_SYSTEM_MASK = 8'd1;

    localparam int NUM_GROUPS = 12;

    // Groups in decreasing priority; the last one catches everything.
    localparam word_t GROUP_TABLE [NUM_GROUPS] = '{
        32'h0000_0100, 32'h0000_0040, 32'hf800_0000, 32'h0000_0200,
        32'h0000_0080, 32'h0000_0010, 32'h0000_3000, 32'h0000_0020,
        32'h03ff_8c00, 32'h4000_0000, 32'h0000_4000, 32'hffff_ffff
    };

    localparam irq_num_t RECORD_LIMIT = 5'd4;

    typedef struct packed {
        cause_t cause_word;
        cause_t cause_enable;
        half_t  memory_flags;
        half_t  dsp_control;
        word_t  audio_control;
        word_t  port0_control;
        word_t  port1_control;
        word_t  port2_control;
    } in_item_t;

    typedef struct packed {
        logic     taken;
        irq_num_t interrupt_number;
        word_t    pending_vector;
        logic     record_last;
    } out_item_t;

    typedef struct packed {
        word_t user_mask;
        word_t system_mask;
    } masks_t;

endpackage

FILE: hdl/isps_channels.sv
// ----------------------------------------------------------------------------
// isps_channels: valid/ready channel interfaces
// Snapshot input channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface isps_item_if;
    logic               valid;
    logic               ready;
    isps_pkg::cause_t   cause_word;
    isps_pkg::cause_t   cause_enable;
    isps_pkg::half_t    memory_flags;
    isps_pkg::half_t    dsp_control;
    isps_pkg::word_t    audio_control;
    isps_pkg::word_t    port0_control;
    isps_pkg::word_t    port1_control;
    isps_pkg::word_t    port2_control;

    modport source (output valid, cause_word, cause_enable, memory_flags, dsp_control,
                    audio_control, port0_control, port1_control, port2_control,
                    input ready);
    modport sink   (input valid, cause_word, cause_enable, memory_flags, dsp_control,
                    audio_control, port0_control, port1_control, port2_control,
                    output ready);
endinterface

interface isps_result_if;
    logic               valid;
    logic               ready;
    logic               taken;
    isps_pkg::irq_num_t interrupt_number;
    isps_pkg::word_t    pending_vector;
    logic               record_last;

    modport source (output valid, taken, interrupt_number, pending_vector, record_last,
                    input ready);
    modport sink   (input valid, taken, interrupt_number, pending_vector, record_last,
                    output ready);
endinterface

interface isps_cfg_if;
    logic                 valid;
    logic                 ready;
    isps_pkg::cfg_index_t index;
    isps_pkg::word_t      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/isps_cfg_regs.sv
// ----------------------------------------------------------------------------
// isps_cfg_regs: mask register file
// Holds the user and system mask registers written over the config channel.
// ----------------------------------------------------------------------------
module isps_cfg_regs import isps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    isps_cfg_if.sink    cfg,
    output masks_t      masks
);

    word_t user_mask_reg;
    word_t system_mask_reg;

    assign cfg.ready = 1'b1;

    // Writes to indexes beyond the two masks are accepted and dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_mask_reg   <= '0;
            system_mask_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_USER_MASK:   user_mask_reg   <= cfg.data;
                REG_SYSTEM_MASK: system_mask_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    assign masks.user_mask   = user_mask_reg;
    assign masks.system_mask = system_mask_reg;

endmodule

FILE: hdl/isps_map_select.sv
// ----------------------------------------------------------------------------
// isps_map_select: source remap, masking and priority encode
// Turns one status snapshot into the pending vector and the chosen interrupt.
// ----------------------------------------------------------------------------
module isps_map_select import isps_pkg::*;
(
    input  in_item_t  item,
    input  masks_t    masks,
    output out_item_t result
);

    word_t    raw_vec;
    word_t    vec;
    word_t    group_bits;
    logic     gate_open;
    logic     group_found;
    irq_num_t num;

    assign gate_open = |(item.cause_word[15:0] & item.cause_enable[15:0]);

    // Bit 31 of the vector is OS interrupt 0.
    always_comb
    begin
        raw_vec = '0;
        if (item.cause_word[7])
        begin
            raw_vec[31:27] = {item.memory_flags[0], item.memory_flags[1],
                              item.memory_flags[2], item.memory_flags[3],
                              item.memory_flags[4]};
        end
        if (item.cause_word[6])
        begin
            raw_vec[26] = item.dsp_control[3];
            raw_vec[25] = item.dsp_control[5];
            raw_vec[24] = item.dsp_control[7];
        end
        if (item.cause_word[5])
        begin
            raw_vec[23] = item.audio_control[3];
        end
        if (item.cause_word[4])
        begin
            raw_vec[22] = item.port0_control[1];
            raw_vec[21] = item.port0_control[3];
            raw_vec[20] = item.port0_control[11];
            raw_vec[19] = item.port1_control[1];
            raw_vec[18] = item.port1_control[3];
            raw_vec[17] = item.port1_control[11];
            raw_vec[16] = item.port2_control[1];
            raw_vec[15] = item.port2_control[3];
        end
        raw_vec[14] = item.cause_word[11];
        raw_vec[13] = item.cause_word[9];
        raw_vec[12] = item.cause_word[10];
        raw_vec[11] = item.cause_word[3];
        raw_vec[10] = item.cause_word[2];
        raw_vec[9]  = item.cause_word[1];
        raw_vec[8]  = item.cause_word[0];
        raw_vec[7]  = item.cause_word[8];
        raw_vec[6]  = item.cause_word[12];
        raw_vec[5]  = item.cause_word[13];
        raw_vec[4]  = item.cause_word[14];
    end

    assign vec = gate_open ? (raw_vec & ~(masks.user_mask | masks.system_mask)) : '0;

    // Walk the table from lowest priority up so the first non-empty group wins.
    always_comb
    begin
        group_bits  = '0;
        group_found = 1'b0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (|(vec & GROUP_TABLE[g]))
            begin
                group_bits  = vec & GROUP_TABLE[g];
                group_found = 1'b1;
            end
        end
    end

    // Leading-zero count: the highest set bit overrides the lower ones.
    always_comb
    begin
        num = '0;
        for (int b = 0; b < 32; b++)
        begin
            if (group_bits[b])
            begin
                num = irq_num_t'(31 - b);
            end
        end
    end

    assign result.taken            = group_found;
    assign result.interrupt_number = num;
    assign result.pending_vector   = vec;
    assign result.record_last      = group_found && (num > RECORD_LIMIT);

endmodule

FILE: hdl/interrupt_source_priority_select.sv
// ----------------------------------------------------------------------------
// interrupt_source_priority_select: interrupt source priority selector
// Registers a status snapshot, remaps and masks it, and picks one interrupt.
// ----------------------------------------------------------------------------
// Each beat on in_item is one snapshot of the interrupt status registers; each
// beat on result carries the selection for one snapshot, in order. Every
// snapshot gives exactly one result beat, with taken low when nothing is
// pending after the cause gate and the masks.
// The snapshot is captured in an input register, the remap, masking and
// priority encode are combinational, and the result sits in an output
// register that drives result valid. A new snapshot is accepted every
// cycle while the receiver takes each result beat: one beat per cycle.
// When the receiver stalls, the output register holds its beat and the input
// register keeps accepting until it too is full; ready on in_item then drops
// until the result beat is taken.
// The cfg channel is always ready; index 0 writes the user mask, index 1 the
// system mask, other indexes are dropped. Write masks only while idle.
// Reset clears both masks and empties both registers; no clearing pass.
// ----------------------------------------------------------------------------
module interrupt_source_priority_select import isps_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    isps_item_if.sink     in_item,
    isps_result_if.source result,
    isps_cfg_if.sink      cfg
);

    masks_t    masks;
    in_item_t  in_data;
    in_item_t  stage_reg;
    logic      stage_valid_reg;
    out_item_t sel_result;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      out_load;
    logic      stage_load;

    isps_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .masks (masks)
    );

    isps_map_select u_map_select
    (
        .item   (stage_reg),
        .masks  (masks),
        .result (sel_result)
    );

    assign in_data.cause_word    = in_item.cause_word;
    assign in_data.cause_enable  = in_item.cause_enable;
    assign in_data.memory_flags  = in_item.memory_flags;
    assign in_data.dsp_control   = in_item.dsp_control;
    assign in_data.audio_control = in_item.audio_control;
    assign in_data.port0_control = in_item.port0_control;
    assign in_data.port1_control = in_item.port1_control;
    assign in_data.port2_control = in_item.port2_control;

    // The output register loads whenever it is empty or its beat leaves now.
    assign out_load      = !out_valid_reg || result.ready;
    assign stage_load    = !stage_valid_reg || out_load;
    assign in_item.ready = stage_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (stage_load)
            begin
                stage_valid_reg <= in_item.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_load && in_item.valid)
        begin
            stage_reg <= in_data;
        end
        if (out_load && stage_valid_reg)
        begin
            out_reg <= sel_result;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.taken            = out_reg.taken;
    assign result.interrupt_number = out_reg.interrupt_number;
    assign result.pending_vector   = out_reg.pending_vector;
    assign result.record_last      = out_reg.record_last;

endmodule

FILE: sim/tb_interrupt_source_priority_select.sv
// ----------------------------------------------------------------------------
// tb_interrupt_source_priority_select: self-checking bench of the selector
// Drives status snapshots and mask writes over valid/ready channels, predicts
// the remapped and masked pending vector and the chosen interrupt number for
// every accepted snapshot, and compares each result beat field by field.
// ----------------------------------------------------------------------------
module tb_interrupt_source_priority_select;
    import isps_pkg::*;

    localparam int QUIET_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int GROUP_COUNT   = 12;

    typedef enum int {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    // Priority groups, highest first; the last one takes whatever is left.
    function automatic word_t group_mask(int g);
        case (g)
            0:       return 32'h0000_0100;
            1:       return 32'h0000_0040;
            2:       return 32'hf800_0000;
            3:       return 32'h0000_0200;
            4:       return 32'h0000_0080;
            5:       return 32'h0000_0010;
            6:       return 32'h0000_3000;
            7:       return 32'h0000_0020;
            8:       return 32'h03ff_8c00;
            9:       return 32'h4000_0000;
            10:      return 32'h0000_4000;
            default: return 32'hffff_ffff;
        endcase
    endfunction

    // OS interrupt raised directly by a main cause bit, or -1 for none.
    function automatic int direct_irq(int b);
        case (b)
            0:       return 23;
            1:       return 22;
            2:       return 21;
            3:       return 20;
            8:       return 24;
            9:       return 18;
            10:      return 19;
            11:      return 17;
            12:      return 25;
            13:      return 26;
            14:      return 27;
            default: return -1;
        endcase
    endfunction

    class irq_scoreboard;
        word_t             user_mask;
        word_t             system_mask;
        out_item_t         selections_q[$];
        int                errors;
        int                snapshots;
        int                results;
        int                taken_count;
        int                record_count;
        logic [GROUP_COUNT-1:0] groups_seen;

        function new();
            user_mask    = '0;
            system_mask  = '0;
            errors       = 0;
            snapshots    = 0;
            results      = 0;
            taken_count  = 0;
            record_count = 0;
            groups_seen  = '0;
        endfunction

        function word_t irq_bit(int n);
            return 32'h8000_0000 >> n;
        endfunction

        function void write_reg(cfg_index_t idx, word_t value);
            if (idx == REG_USER_MASK)
                user_mask = value;
            else if (idx == REG_SYSTEM_MASK)
                system_mask = value;
        endfunction

        function out_item_t select_irq(in_item_t s);
            out_item_t r;
            word_t     vec;
            word_t     grp;
            int        n;
            r   = '0;
            vec = '0;
            // Bit 16 of the cause word never opens the gate.
            if ((s.cause_word[15:0] & s.cause_enable[15:0]) == 16'h0)
                return r;
            if (s.cause_word[7])
                for (int i = 0; i < 5; i++)
                    if (s.memory_flags[i])
                        vec |= irq_bit(i);
            if (s.cause_word[6])
            begin
                if (s.dsp_control[3]) vec |= irq_bit(5);
                if (s.dsp_control[5]) vec |= irq_bit(6);
                if (s.dsp_control[7]) vec |= irq_bit(7);
            end
            if (s.cause_word[5] && s.audio_control[3])
                vec |= irq_bit(8);
            if (s.cause_word[4])
            begin
                if (s.port0_control[1])  vec |= irq_bit(9);
                if (s.port0_control[3])  vec |= irq_bit(10);
                if (s.port0_control[11]) vec |= irq_bit(11);
                if (s.port1_control[1])  vec |= irq_bit(12);
                if (s.port1_control[3])  vec |= irq_bit(13);
                if (s.port1_control[11]) vec |= irq_bit(14);
                if (s.port2_control[1])  vec |= irq_bit(15);
                if (s.port2_control[3])  vec |= irq_bit(16);
            end
            for (int b = 0; b < 15; b++)
                if (direct_irq(b) >= 0 && s.cause_word[b])
                    vec |= irq_bit(direct_irq(b));
            vec &= ~(user_mask | system_mask);
            if (vec == '0)
                return r;
            for (int g = 0; g < GROUP_COUNT; g++)
            begin
                grp = vec & group_mask(g);
                if (grp != '0)
                begin
                    n = 0;
                    while (!grp[31 - n])
                        n++;
                    r.taken            = 1'b1;
                    r.interrupt_number = irq_num_t'(n);
                    r.record_last      = (n > 4);
                    groups_seen[g]     = 1'b1;
                    break;
                end
            end
            r.pending_vector = vec;
            return r;
        endfunction

        function void note_snapshot(in_item_t s);
            snapshots++;
            selections_q.push_back(select_irq(s));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results++;
            if (selections_q.size() == 0)
            begin
                $error("result beat with no snapshot outstanding");
                errors++;
                return;
            end
            want = selections_q.pop_front();
            if (want.taken)       taken_count++;
            if (want.record_last) record_count++;
            if (got.taken !== want.taken)
            begin
                $error("taken: expected %0d, actual %0d", want.taken, got.taken);
                errors++;
            end
            if (got.interrupt_number !== want.interrupt_number)
            begin
                $error("interrupt_number: expected %0d, actual %0d",
                       want.interrupt_number, got.interrupt_number);
                errors++;
            end
            if (got.pending_vector !== want.pending_vector)
            begin
                $error("pending_vector: expected %08h, actual %08h",
                       want.pending_vector, got.pending_vector);
                errors++;
            end
            if (got.record_last !== want.record_last)
            begin
                $error("record_last: expected %0d, actual %0d",
                       want.record_last, got.record_last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    isps_item_if   in_ch ();
    isps_result_if res_ch ();
    isps_cfg_if    cfg_ch ();

    interrupt_source_priority_select uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_ch),
        .result  (res_ch),
        .cfg     (cfg_ch)
    );

    irq_scoreboard sb;
    int            sent_total;
    int            quiet_cycles;
    int            mask_writes;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // The pacing changes every hundred snapshots so gaps land on every phase.
    function automatic pace_t pace_now();
        return pace_t'((sent_total / 100) % 4);
    endfunction

    function automatic bit sender_idles();
        case (pace_now())
            PACE_SEND_IDLE: return $urandom_range(99) < 62;
            PACE_BOTH:      return $urandom_range(99) < 16;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (pace_now())
            PACE_RECV_STALL: return $urandom_range(99) < 62;
            PACE_BOTH:       return $urandom_range(99) < 16;
            default:         return 1'b0;
        endcase
    endfunction

    always @(negedge clk)
        res_ch.ready = !receiver_stalls();

    // Monitor and watchdog: every beat is sampled at the rising edge.
    always @(posedge clk)
    begin
        in_item_t  snap;
        out_item_t res;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready)
            begin
                snap.cause_word    = in_ch.cause_word;
                snap.cause_enable  = in_ch.cause_enable;
                snap.memory_flags  = in_ch.memory_flags;
                snap.dsp_control   = in_ch.dsp_control;
                snap.audio_control = in_ch.audio_control;
                snap.port0_control = in_ch.port0_control;
                snap.port1_control = in_ch.port1_control;
                snap.port2_control = in_ch.port2_control;
                sb.note_snapshot(snap);
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                res.taken            = res_ch.taken;
                res.interrupt_number = res_ch.interrupt_number;
                res.pending_vector   = res_ch.pending_vector;
                res.record_last      = res_ch.record_last;
                sb.check_result(res);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                sb.write_reg(cfg_ch.index, cfg_ch.data);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic drive_snapshot_fields(in_item_t s);
        in_ch.cause_word    = s.cause_word;
        in_ch.cause_enable  = s.cause_enable;
        in_ch.memory_flags  = s.memory_flags;
        in_ch.dsp_control   = s.dsp_control;
        in_ch.audio_control = s.audio_control;
        in_ch.port0_control = s.port0_control;
        in_ch.port1_control = s.port1_control;
        in_ch.port2_control = s.port2_control;
    endtask

    task automatic send_snapshot(in_item_t s);
        in_item_t junk;
        @(negedge clk);
        while (sender_idles())
        begin
            // Idle cycles carry noise on the payload.
            junk = in_item_t'({$urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom});
            in_ch.valid = 1'b0;
            drive_snapshot_fields(junk);
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        drive_snapshot_fields(s);
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sent_total++;
    endtask

    // Stop sending and wait until every outstanding result has been taken.
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.selections_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(cfg_index_t idx, word_t value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
        mask_writes++;
    endtask

    task automatic set_masks(word_t user_value, word_t system_value);
        wait_idle();
        write_mask(REG_USER_MASK, user_value);
        write_mask(REG_SYSTEM_MASK, system_value);
        // An index outside the register map must leave both masks alone.
        write_mask(cfg_index_t'($urandom_range(255, REG_SYSTEM_MASK + 1)), $urandom);
    endtask

    function automatic in_item_t full_snapshot();
        in_item_t s;
        s = '1;
        return s;
    endfunction

    function automatic in_item_t random_snapshot();
        in_item_t s;
        int       style;
        style           = $urandom_range(99);
        s.memory_flags  = half_t'($urandom);
        s.dsp_control   = half_t'($urandom);
        s.audio_control = $urandom;
        s.port0_control = $urandom;
        s.port1_control = $urandom;
        s.port2_control = $urandom;
        if (style < 45)
        begin
            // Few sources at once, so the lower priority groups get selected.
            s.cause_word = '0;
            repeat ($urandom_range(3, 1))
                s.cause_word[$urandom_range(16)] = 1'b1;
            s.cause_enable  = cause_t'($urandom) | s.cause_word;
            s.port0_control = $urandom & $urandom;
            s.port1_control = $urandom & $urandom;
        end
        else if (style < 85)
        begin
            s.cause_word   = cause_t'($urandom);
            s.cause_enable = cause_t'($urandom);
        end
        else
        begin
            // Gate closed: enable covers none of the set low cause bits.
            s.cause_word   = cause_t'($urandom);
            s.cause_enable = ~s.cause_word;
            s.cause_enable[16] = 1'($urandom_range(1));
        end
        return s;
    endfunction

    function automatic word_t sparse_word();
        return $urandom & $urandom & $urandom;
    endfunction

    task automatic run_directed();
        in_item_t s;
        s = '0;
        send_snapshot(s);
        s.cause_word = '1;
        send_snapshot(s);
        s = full_snapshot();
        s.cause_word = 17'h1_0000;
        send_snapshot(s);
        send_snapshot(full_snapshot());
        for (int b = 0; b < 17; b++)
        begin
            s = full_snapshot();
            s.cause_word = '0;
            s.cause_word[b] = 1'b1;
            send_snapshot(s);
        end
        s = '0;
        s.cause_enable  = '1;
        s.cause_word[7] = 1'b1;
        s.memory_flags  = 16'h0010;
        send_snapshot(s);
        s = '0;
        s.cause_enable  = '1;
        s.cause_word[4] = 1'b1;
        s.port2_control = 32'h0000_0008;
        send_snapshot(s);
        s.port2_control = '0;
        s.port0_control = 32'h0000_0800;
        send_snapshot(s);

        // Masks: everything hidden, then only interrupt zero let through, then everything hidden again.
        set_masks(32'hffff_ffff, 32'h0000_0000);
        send_snapshot(full_snapshot());
        set_masks(32'h0000_0000, 32'hffff_ffff);
        send_snapshot(full_snapshot());
        set_masks(32'h0000_0000, 32'h7fff_ffff);
        s = '0;
        s.cause_enable  = '1;
        s.cause_word[7] = 1'b1;
        s.memory_flags  = 16'h001f;
        send_snapshot(s);
        set_masks(32'h8000_0000, 32'h7fff_ffff);
        send_snapshot(s);
    endtask

    initial
    begin
        word_t um;
        word_t sm;
        int    count;
        sb           = new();
        sent_total   = 0;
        quiet_cycles = 0;
        mask_writes  = 0;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        drive_snapshot_fields('0);
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();

        for (int phase = 0; phase < 9; phase++)
        begin
            count = 180;
            case (phase % 5)
                0:
                begin
                    um = '0;
                    sm = '0;
                end
                1:
                begin
                    um = sparse_word();
                    sm = sparse_word();
                end
                2:
                begin
                    um = $urandom;
                    sm = '0;
                end
                3:
                begin
                    um = '0;
                    sm = $urandom;
                end
                default:
                begin
                    um    = sparse_word();
                    sm    = 32'hffff_ffff;
                    count = 40;
                end
            endcase
            set_masks(um, sm);
            for (int i = 0; i < count; i++)
            begin
                // Once, hold the snapshots back until the pipe has emptied.
                if (phase == 1 && i == count / 2)
                    wait_idle();
                send_snapshot(random_snapshot());
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (sb.selections_q.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.selections_q.size());
            sb.errors++;
        end

        $display("Covered %0d snapshots and %0d result beats, %0d taken, %0d past number 4.",
                 sb.snapshots, sb.results, sb.taken_count, sb.record_count);
        $display("Priority groups reached: %b, mask register writes: %0d.",
                 sb.groups_seen, mask_writes);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
